// ===== design/length_prefixed_message_ring_macros.svh =====
// ---------------------------------------------------------------------------
// Length-prefixed message ring assertion macros
// Concurrent assertion wrappers on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_MESSAGE_RING_MACROS_SVH
`define LENGTH_PREFIXED_MESSAGE_RING_MACROS_SVH

`ifndef SYNTHESIS

// Check that a property holds at every clock edge out of reset.
`define LPMR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds out of reset.
`define LPMR_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define LPMR_ASSERT(lbl, prop, msg)
`define LPMR_NEVER(lbl, cond, msg)

`endif

`endif

// ===== design/lpmr_pkg.sv =====
// ---------------------------------------------------------------------------
// lpmr_pkg
// Shared codes, defaults and controller/datapath interface structs.
// ---------------------------------------------------------------------------
`default_nettype none

package lpmr_pkg;

  localparam int RING_BYTES_DEF   = 1024;
  localparam int HEADER_BYTES_DEF = 4;

  typedef enum logic [1:0] {
    OP_SEND_HDR  = 2'd0,
    OP_SEND_DATA = 2'd1,
    OP_RECV_HDR  = 2'd2,
    OP_RECV_DATA = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_FULL  = 3'd1,
    ST_EMPTY = 3'd2,
    ST_SMALL = 3'd3,
    ST_FAIL  = 3'd4
  } status_t;

  typedef struct packed {
    logic    load;        // latch the accepted item
    logic    hcnt_inc;    // advance header byte counter
    logic    mem_we_hdr;  // write one header byte
    logic    mem_we_data; // write the data byte
    logic    mem_re;      // read the ring
    logic    rd_next;     // read at the next header byte
    logic    capture;     // shift read byte into header
    logic    set_send;    // open outgoing message
    logic    consume;     // drop header, open incoming message
    logic    pop;         // advance read count by one byte
    logic    finish;      // emit a result
    status_t status;
    logic    emit_len;
    logic    emit_byte;
  } dp_cmd_t;

  typedef struct packed {
    op_t  op;
    logic len_zero;
    logic send_open;
    logic send_full;
    logic recv_open;
    logic fill_short;
    logic fill_zero;
    logic hcnt_last;
    logic hdr_big;
    logic hdr_small;
    logic hdr_short;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== design/lpmr_ram.sv =====
// ---------------------------------------------------------------------------
// lpmr_ram
// Single-port RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module lpmr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = lpmr_pkg::RING_BYTES_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== design/lpmr_ctrl.sv =====
// ---------------------------------------------------------------------------
// lpmr_ctrl
// Sequencer: checks each item, steps header writes and reads, emits results.
// ---------------------------------------------------------------------------
`default_nettype none

module lpmr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  lpmr_pkg::dp_stat_t  stat,
  output lpmr_pkg::dp_cmd_t   cmd
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_EVAL   = 6'b000010,
    S_HWRITE = 6'b000100,
    S_HREAD  = 6'b001000,
    S_HCHECK = 6'b010000,
    S_DREAD  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    cmd.status = lpmr_pkg::ST_OK;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        state_nxt = S_IDLE;
        case (stat.op)
          lpmr_pkg::OP_SEND_HDR: begin
            if (stat.len_zero || stat.send_open) begin
              cmd.finish = 1'b1;
              cmd.status = lpmr_pkg::ST_FAIL;
            end else if (stat.send_full) begin
              cmd.finish = 1'b1;
              cmd.status = lpmr_pkg::ST_FULL;
            end else begin
              state_nxt = S_HWRITE;
            end
          end
          lpmr_pkg::OP_SEND_DATA: begin
            cmd.finish = 1'b1;
            if (!stat.send_open) begin
              cmd.status = lpmr_pkg::ST_FAIL;
            end else begin
              cmd.mem_we_data = 1'b1;
            end
          end
          lpmr_pkg::OP_RECV_HDR: begin
            if (stat.recv_open) begin
              cmd.finish = 1'b1;
              cmd.status = lpmr_pkg::ST_FAIL;
            end else if (stat.fill_short) begin
              cmd.finish = 1'b1;
              cmd.status = lpmr_pkg::ST_EMPTY;
            end else begin
              cmd.mem_re = 1'b1;
              state_nxt  = S_HREAD;
            end
          end
          lpmr_pkg::OP_RECV_DATA: begin
            if (!stat.recv_open || stat.fill_zero) begin
              cmd.finish = 1'b1;
              cmd.status = lpmr_pkg::ST_EMPTY;
            end else begin
              cmd.mem_re = 1'b1;
              state_nxt  = S_DREAD;
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_HWRITE: begin
        cmd.mem_we_hdr = 1'b1;
        cmd.hcnt_inc   = 1'b1;
        if (stat.hcnt_last) begin
          cmd.set_send = 1'b1;
          cmd.finish   = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_HREAD: begin
        cmd.capture  = 1'b1;
        cmd.hcnt_inc = 1'b1;
        cmd.mem_re   = 1'b1;
        cmd.rd_next  = 1'b1;
        if (stat.hcnt_last) begin
          state_nxt = S_HCHECK;
        end
      end
      S_HCHECK: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
        if (stat.hdr_big) begin
          cmd.status = lpmr_pkg::ST_FAIL;
        end else if (stat.hdr_small) begin
          cmd.status = lpmr_pkg::ST_SMALL;
        end else if (stat.hdr_short) begin
          cmd.status = lpmr_pkg::ST_EMPTY;
        end else begin
          cmd.consume  = 1'b1;
          cmd.emit_len = 1'b1;
        end
      end
      S_DREAD: begin
        cmd.pop       = 1'b1;
        cmd.finish    = 1'b1;
        cmd.emit_byte = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/lpmr_dp.sv =====
// ---------------------------------------------------------------------------
// lpmr_dp
// Ring counters, byte store, header assembly and result registers.
// ---------------------------------------------------------------------------
`default_nettype none

module lpmr_dp #(
  parameter int RING_BYTES   = lpmr_pkg::RING_BYTES_DEF,
  parameter int HEADER_BYTES = lpmr_pkg::HEADER_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [1:0]         in_operation,
  input  logic [15:0]        in_length_or_capacity,
  input  logic [7:0]         in_data_byte,
  input  lpmr_pkg::dp_cmd_t  cmd,
  output lpmr_pkg::dp_stat_t stat,
  output logic               out_valid,
  output logic [2:0]         out_status,
  output logic [10:0]        out_message_length,
  output logic [7:0]         out_data_out,
  output logic               out_last
);

  localparam int AW   = $clog2(RING_BYTES);
  localparam int CW   = AW + 1;
  localparam int HCW  = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;
  localparam int HW   = 8 * HEADER_BYTES;
  localparam int CMPW = ((CW > 16) ? CW : 16) + 1;
  localparam int XW   = ((HW > CMPW) ? HW : CMPW) + 1;

  lpmr_pkg::op_t     op_r;
  logic [15:0]       len_r;
  logic [7:0]        byte_r;
  logic [HCW-1:0]    hcnt_r;
  logic [HW-1:0]     hdr_r, hdr_nxt;
  logic [CW-1:0]     wc_r, rc_r, send_left_r, recv_left_r;
  logic              out_valid_r;
  lpmr_pkg::status_t out_status_r;
  logic [10:0]       out_len_r;
  logic [7:0]        out_data_r;
  logic              out_last_r;

  logic [CW-1:0]     fill, room;
  logic [CMPW-1:0]   len_ext;
  logic [XW-1:0]     hdr_ext;
  logic [15:0]       len_shift;
  logic              mem_we;
  logic [AW-1:0]     rd_idx, mem_addr;
  logic [7:0]        mem_wdata, mem_rdata;

  assign fill      = CW'(wc_r - rc_r);
  assign room      = CW'(RING_BYTES) - fill;
  assign len_ext   = CMPW'(len_r);
  assign hdr_ext   = XW'(hdr_r);
  assign len_shift = len_r >> {hcnt_r, 3'b000};

  // Header bytes arrive low byte first; shift in from the top.
  generate
    if (HW > 8) begin : g_hdr_wide
      assign hdr_nxt = {mem_rdata, hdr_r[HW-1:8]};
    end else begin : g_hdr_byte
      assign hdr_nxt = mem_rdata;
    end
  endgenerate

  assign stat.op         = op_r;
  assign stat.len_zero   = (len_r == 16'd0);
  assign stat.send_open  = (send_left_r != '0);
  assign stat.send_full  = (len_ext + CMPW'(HEADER_BYTES)) > CMPW'(room);
  assign stat.recv_open  = (recv_left_r != '0);
  assign stat.fill_short = (fill < CW'(HEADER_BYTES));
  assign stat.fill_zero  = (fill == '0);
  assign stat.hcnt_last  = (hcnt_r == HCW'(HEADER_BYTES - 1));
  assign stat.hdr_big    = (hdr_ext > XW'(RING_BYTES));
  assign stat.hdr_small  = (hdr_ext > XW'(len_r));
  assign stat.hdr_short  = (XW'(fill) < (hdr_ext + XW'(HEADER_BYTES)));

  assign mem_we    = cmd.mem_we_hdr | cmd.mem_we_data;
  assign mem_wdata = cmd.mem_we_hdr ? len_shift[7:0] : byte_r;
  assign rd_idx    = rc_r[AW-1:0] + (cmd.rd_next ? (AW'(hcnt_r) + AW'(1)) : AW'(0));
  assign mem_addr  = mem_we ? wc_r[AW-1:0] : rd_idx;

  lpmr_ram #(
    .WIDTH (8),
    .DEPTH (RING_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .re    (cmd.mem_re),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= lpmr_pkg::op_t'(in_operation);
      len_r  <= in_length_or_capacity;
      byte_r <= in_data_byte;
      hcnt_r <= '0;
    end else if (cmd.hcnt_inc) begin
      hcnt_r <= hcnt_r + HCW'(1);
    end
    if (cmd.capture) begin
      hdr_r <= hdr_nxt;
    end
    if (cmd.finish) begin
      out_status_r <= cmd.status;
      out_len_r    <= cmd.emit_len ? hdr_ext[10:0] : 11'd0;
      out_data_r   <= cmd.emit_byte ? mem_rdata : 8'd0;
      out_last_r   <= cmd.emit_byte && (recv_left_r == CW'(1));
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wc_r        <= '0;
      rc_r        <= '0;
      send_left_r <= '0;
      recv_left_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
      if (mem_we) begin
        wc_r <= wc_r + CW'(1);
      end
      if (cmd.set_send) begin
        send_left_r <= len_ext[CW-1:0];
      end else if (cmd.mem_we_data) begin
        send_left_r <= send_left_r - CW'(1);
      end
      if (cmd.consume) begin
        rc_r        <= rc_r + CW'(HEADER_BYTES);
        recv_left_r <= hdr_ext[CW-1:0];
      end else if (cmd.pop) begin
        rc_r        <= rc_r + CW'(1);
        recv_left_r <= recv_left_r - CW'(1);
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_message_length = out_len_r;
  assign out_data_out       = out_data_r;
  assign out_last           = out_last_r;

endmodule

`default_nettype wire

// ===== design/length_prefixed_message_ring.sv =====
// ---------------------------------------------------------------------------
// length_prefixed_message_ring
// Byte ring carrying length-prefixed messages between one sender and one
// receiver.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel: drive in_operation, in_length_or_capacity and in_data_byte
//   with start high; the transfer happens at the edge where busy is low.
//   Operations are send header, send data byte, receive header and receive
//   data byte. Each transfer produces exactly one result.
//   Result channel: out_valid is high for one cycle with out_status,
//   out_message_length, out_data_out and out_last. The receiver cannot stall;
//   a result must be taken in the cycle it is shown.
//   Steps, from the accepting edge to the result strobe:
//     send data byte, or item refused before any ring read: decided in S_EVAL
//     receive data byte: S_EVAL starts the registered RAM read, S_DREAD emits
//     send header: S_EVAL, then one S_HWRITE step per header byte
//     receive header past the fill check, taken or refused: S_EVAL, S_HREAD
//     per header byte, then S_HCHECK. The next item can be accepted in the
//   cycle the result is shown, not before. The pace is set by the single ring
//   RAM port, which moves one byte per access, and its registered read data.
//   Reset (rst_n low, synchronous) empties the ring and closes any open
//   message; ring contents stay undefined and need no clearing pass.
// ---------------------------------------------------------------------------
`default_nettype none

`include "length_prefixed_message_ring_macros.svh"

module length_prefixed_message_ring #(
  parameter int RING_BYTES   = lpmr_pkg::RING_BYTES_DEF,
  parameter int HEADER_BYTES = lpmr_pkg::HEADER_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_operation,
  input  logic [15:0] in_length_or_capacity,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [10:0] out_message_length,
  output logic [7:0]  out_data_out,
  output logic        out_last
);

  // Commands from the sequencer, status flags back from the datapath.
  lpmr_pkg::dp_cmd_t  cmd;
  lpmr_pkg::dp_stat_t stat;

  lpmr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  lpmr_dp #(
    .RING_BYTES   (RING_BYTES),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_operation          (in_operation),
    .in_length_or_capacity (in_length_or_capacity),
    .in_data_byte          (in_data_byte),
    .cmd                   (cmd),
    .stat                  (stat),
    .out_valid             (out_valid),
    .out_status            (out_status),
    .out_message_length    (out_message_length),
    .out_data_out          (out_data_out),
    .out_last              (out_last)
  );

  // An accepted transfer holds the block busy in the following cycle.
  `LPMR_ASSERT(a_accept_busy, (start && !busy) |=> busy, "no busy after accepted transfer")
  // Every item passes through S_IDLE and S_EVAL, so result strobes never touch.
  `LPMR_ASSERT(a_strobe_gap, out_valid |=> !out_valid, "back-to-back result strobes")
  // A last flag or a message length belongs only to a successful result.
  `LPMR_ASSERT(a_last_ok, (out_valid && (out_last || (out_message_length != 11'd0)))
    |-> (out_status == lpmr_pkg::ST_OK), "last or length on failed result")
  // The single RAM port never reads and writes in the same cycle.
  `LPMR_NEVER(a_port_clash, (cmd.mem_re && (cmd.mem_we_hdr || cmd.mem_we_data)),
    "ring read and write in one cycle")

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// ---------------------------------------------------------------------------
// Message ring bench
// Drives a short table of directed transfers into the message ring, then
// random sender/receiver traffic under several idle patterns. A ring
// predictor built into the bench checks each result not typed in, field by field.
// ---------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING         = lpmr_pkg::RING_BYTES_DEF;
  localparam int HDR          = lpmr_pkg::HEADER_BYTES_DEF;
  localparam int CNT_MASK     = 2 * RING - 1;
  localparam int IDX_MASK     = RING - 1;
  localparam int RANDOM_ITEMS = 1800;
  localparam int PHASES       = 4;
  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 16;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    lpmr_pkg::status_t status;
    logic [10:0]       msg_len;
    logic [7:0]        data;
    logic              last;
  } ring_result_t;

  typedef struct packed {
    lpmr_pkg::op_t op;
    logic [15:0]   arg;
    logic [7:0]    payload;
    logic          pinned;
    ring_result_t  res;
  } stim_row_t;

  // DUT connections; every input starts at a known value
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_operation = '0;
  logic [15:0] in_length_or_capacity = '0;
  logic [7:0]  in_data_byte = '0;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [10:0] out_message_length;
  logic [7:0]  out_data_out;
  logic        out_last;

  // Shadow copy of the ring: bytes, free-running counts, open-message counters
  logic [7:0] shadow_ring [RING];
  int         ring_wr = 0;
  int         ring_rd = 0;
  int         send_left = 0;
  int         recv_left = 0;
  int         peak_fill = 0;

  ring_result_t pending_results [$];
  stim_row_t    directed_rows [$];

  int transfers = 0;
  int results_seen = 0;
  int mismatches = 0;
  int cycles = 0;
  int status_hits [8] = '{default: 0};

  length_prefixed_message_ring #(
    .RING_BYTES   (RING),
    .HEADER_BYTES (HDR)
  ) uut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_operation          (in_operation),
    .in_length_or_capacity (in_length_or_capacity),
    .in_data_byte          (in_data_byte),
    .out_valid             (out_valid),
    .out_status            (out_status),
    .out_message_length    (out_message_length),
    .out_data_out          (out_data_out),
    .out_last              (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Append one byte at the write count and advance it
  task automatic ring_push(input logic [7:0] b);
    shadow_ring[ring_wr & IDX_MASK] = b;
    ring_wr = (ring_wr + 1) & CNT_MASK;
  endtask

  // Work out the result of one accepted transfer and advance the shadow ring
  task automatic ring_predict(input lpmr_pkg::op_t op, input logic [15:0] arg,
                              input logic [7:0] payload, output ring_result_t res);
    longint      fill;
    longint      hdr;
    logic [31:0] hdr_word;
    int          i;
    res = '0;
    res.status = lpmr_pkg::ST_OK;
    fill = (ring_wr - ring_rd) & CNT_MASK;
    case (op)
      lpmr_pkg::OP_SEND_HDR: begin
        // Reserve room for header plus body up front; refuse while a body is owed
        if (arg == 16'd0 || send_left != 0) begin
          res.status = lpmr_pkg::ST_FAIL;
        end else if (longint'(arg) + HDR > RING - fill) begin
          res.status = lpmr_pkg::ST_FULL;
        end else begin
          hdr_word = 32'(arg);
          for (i = 0; i < HDR; i++) ring_push(hdr_word[8*i +: 8]);
          send_left = int'(arg);
        end
      end
      lpmr_pkg::OP_SEND_DATA: begin
        if (send_left == 0) begin
          res.status = lpmr_pkg::ST_FAIL;
        end else begin
          ring_push(payload);
          send_left--;
        end
      end
      lpmr_pkg::OP_RECV_HDR: begin
        // Take a header only once its whole message sits in the ring
        if (recv_left != 0) begin
          res.status = lpmr_pkg::ST_FAIL;
        end else if (fill < HDR) begin
          res.status = lpmr_pkg::ST_EMPTY;
        end else begin
          hdr = 0;
          for (i = 0; i < HDR; i++)
            hdr = hdr | (longint'(shadow_ring[(ring_rd + i) & IDX_MASK]) << (8 * i));
          if (hdr > RING) begin
            res.status = lpmr_pkg::ST_FAIL;
          end else if (hdr > longint'(arg)) begin
            res.status = lpmr_pkg::ST_SMALL;
          end else if (fill < hdr + HDR) begin
            res.status = lpmr_pkg::ST_EMPTY;
          end else begin
            ring_rd = (ring_rd + HDR) & CNT_MASK;
            recv_left = int'(hdr);
            res.msg_len = 11'(hdr);
          end
        end
      end
      default: begin
        if (recv_left == 0 || fill == 0) begin
          res.status = lpmr_pkg::ST_EMPTY;
        end else begin
          res.data = shadow_ring[ring_rd & IDX_MASK];
          ring_rd = (ring_rd + 1) & CNT_MASK;
          recv_left--;
          res.last = (recv_left == 0);
        end
      end
    endcase
    fill = (ring_wr - ring_rd) & CNT_MASK;
    if (fill > peak_fill) peak_fill = int'(fill);
  endtask

  // Present one item, hold it until the transfer, then log what must come back.
  // Leave start high on return so a follow-on item needs no second assignment.
  task automatic issue(input lpmr_pkg::op_t op, input logic [15:0] arg,
                       input logic [7:0] payload, input logic pinned,
                       input ring_result_t pinned_res);
    ring_result_t want;
    start <= 1'b1;
    in_operation <= op;
    in_length_or_capacity <= arg;
    in_data_byte <= payload;
    do @(posedge clk); while (busy);
    ring_predict(op, arg, payload, want);
    if (pinned) want = pinned_res;
    pending_results.push_back(want);
    transfers++;
  endtask

  // Directed row checked against the predictor
  task automatic add_row(input lpmr_pkg::op_t op, input logic [15:0] arg,
                         input logic [7:0] payload);
    stim_row_t r;
    r = '0;
    r.op = op;
    r.arg = arg;
    r.payload = payload;
    directed_rows.push_back(r);
  endtask

  // Directed row with its result typed in
  task automatic pin_row(input lpmr_pkg::op_t op, input logic [15:0] arg,
                         input logic [7:0] payload, input lpmr_pkg::status_t st,
                         input logic [10:0] mlen, input logic [7:0] dout,
                         input logic lst);
    stim_row_t r;
    r.op = op;
    r.arg = arg;
    r.payload = payload;
    r.pinned = 1'b1;
    r.res.status = st;
    r.res.msg_len = mlen;
    r.res.data = dout;
    r.res.last = lst;
    directed_rows.push_back(r);
  endtask

  // Pick the next random item: mostly well-formed send and receive sequences
  // that follow the shadow state, with a tenth of pure noise mixed in
  task automatic pick_item(input int recv_pct, output lpmr_pkg::op_t op,
                           output logic [15:0] arg, output logic [7:0] payload);
    int roll;
    payload = 8'($urandom_range(255));
    arg = 16'($urandom_range(65535));
    roll = $urandom_range(99);
    if (roll < 10) begin
      op = lpmr_pkg::op_t'(2'($urandom_range(3)));
      if ($urandom_range(1) == 1) arg = 16'($urandom_range(8));
    end else if ($urandom_range(99) >= recv_pct) begin
      if (send_left != 0) begin
        op = lpmr_pkg::OP_SEND_DATA;
      end else begin
        op = lpmr_pkg::OP_SEND_HDR;
        roll = $urandom_range(99);
        // Mostly short messages; a few long ones to fill the ring
        if (roll < 2) arg = 16'($urandom_range(1020, 1000));
        else if (roll < 10) arg = 16'($urandom_range(400, 100));
        else arg = 16'($urandom_range(24, 1));
      end
    end else begin
      if (recv_left != 0) begin
        op = lpmr_pkg::OP_RECV_DATA;
      end else begin
        op = lpmr_pkg::OP_RECV_HDR;
        roll = $urandom_range(99);
        if (roll < 70) arg = 16'hFFFF;
        else if (roll < 85) arg = 16'($urandom_range(32));
      end
    end
  endtask

  initial begin : stimulus
    stim_row_t     row;
    ring_result_t  none;
    lpmr_pkg::op_t op;
    logic [15:0]   arg;
    logic [7:0]    payload;
    int            idle_pct [PHASES];
    int            recv_pct [PHASES];
    int            phase;
    int            n;
    none = '0;
    // Idle patterns: none, sender idle 53%, none, sender idle 33%.
    // The receiver cannot stall, so its stall share has nothing to act on.
    idle_pct = '{0, 53, 0, 33};
    recv_pct = '{45, 45, 50, 50};

    // Empty ring refusals, length extremes, then a two-byte message end to end
    pin_row(lpmr_pkg::OP_RECV_HDR,  16'd100,  8'h00, lpmr_pkg::ST_EMPTY, 11'd0, 8'h00, 1'b0);
    pin_row(lpmr_pkg::OP_RECV_DATA, 16'd0,    8'h00, lpmr_pkg::ST_EMPTY, 11'd0, 8'h00, 1'b0);
    pin_row(lpmr_pkg::OP_SEND_DATA, 16'd0,    8'hAA, lpmr_pkg::ST_FAIL,  11'd0, 8'h00, 1'b0);
    pin_row(lpmr_pkg::OP_SEND_HDR,  16'd0,    8'h00, lpmr_pkg::ST_FAIL,  11'd0, 8'h00, 1'b0);
    pin_row(lpmr_pkg::OP_SEND_HDR,  16'd1021, 8'h00, lpmr_pkg::ST_FULL,  11'd0, 8'h00, 1'b0);
    pin_row(lpmr_pkg::OP_SEND_HDR,  16'hFFFF, 8'hFF, lpmr_pkg::ST_FULL,  11'd0, 8'h00, 1'b0);
    pin_row(lpmr_pkg::OP_SEND_HDR,  16'd2,    8'h00, lpmr_pkg::ST_OK,    11'd0, 8'h00, 1'b0);
    // Header while the previous body is still owed
    pin_row(lpmr_pkg::OP_SEND_HDR,  16'd3,    8'h00, lpmr_pkg::ST_FAIL,  11'd0, 8'h00, 1'b0);
    // Header present but body not yet complete
    pin_row(lpmr_pkg::OP_RECV_HDR,  16'hFFFF, 8'h00, lpmr_pkg::ST_EMPTY, 11'd0, 8'h00, 1'b0);
    pin_row(lpmr_pkg::OP_SEND_DATA, 16'd0,    8'h00, lpmr_pkg::ST_OK,    11'd0, 8'h00, 1'b0);
    pin_row(lpmr_pkg::OP_SEND_DATA, 16'hFFFF, 8'hFF, lpmr_pkg::ST_OK,    11'd0, 8'h00, 1'b0);
    pin_row(lpmr_pkg::OP_SEND_DATA, 16'd0,    8'h55, lpmr_pkg::ST_FAIL,  11'd0, 8'h00, 1'b0);
    // Capacity one short of the message
    pin_row(lpmr_pkg::OP_RECV_HDR,  16'd1,    8'h00, lpmr_pkg::ST_SMALL, 11'd0, 8'h00, 1'b0);
    pin_row(lpmr_pkg::OP_RECV_HDR,  16'd2,    8'h00, lpmr_pkg::ST_OK,    11'd2, 8'h00, 1'b0);
    // Header while the previous body is still being popped
    pin_row(lpmr_pkg::OP_RECV_HDR,  16'd2,    8'h00, lpmr_pkg::ST_FAIL,  11'd0, 8'h00, 1'b0);
    pin_row(lpmr_pkg::OP_RECV_DATA, 16'd0,    8'h00, lpmr_pkg::ST_OK,    11'd0, 8'h00, 1'b0);
    pin_row(lpmr_pkg::OP_RECV_DATA, 16'd0,    8'h00, lpmr_pkg::ST_OK,    11'd0, 8'hFF, 1'b1);
    pin_row(lpmr_pkg::OP_RECV_DATA, 16'd0,    8'h00, lpmr_pkg::ST_EMPTY, 11'd0, 8'h00, 1'b0);
    // One-byte message, zero capacity first
    add_row(lpmr_pkg::OP_SEND_HDR,  16'd1,    8'h00);
    add_row(lpmr_pkg::OP_SEND_DATA, 16'd0,    8'h5A);
    add_row(lpmr_pkg::OP_RECV_HDR,  16'd0,    8'h00);
    add_row(lpmr_pkg::OP_RECV_HDR,  16'd1,    8'h00);
    add_row(lpmr_pkg::OP_RECV_DATA, 16'd0,    8'h00);

    // Hold reset low from time zero, then release it for good
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[k]) begin
      row = directed_rows[k];
      issue(row.op, row.arg, row.payload, row.pinned, row.res);
    end

    for (phase = 0; phase < PHASES; phase++) begin
      for (n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
        // Drop start for a random gap; each cycle idles with the phase's odds
        if ($urandom_range(99) < idle_pct[phase]) begin
          start <= 1'b0;
          do @(posedge clk); while ($urandom_range(99) < idle_pct[phase]);
        end
        pick_item(recv_pct[phase], op, arg, payload);
        issue(op, arg, payload, 1'b0, none);
      end
    end

    // Drain: wait for every outstanding result, then watch a little longer
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d transfers (%0d directed) over %0d idle patterns; %0d results.",
             transfers, directed_rows.size(), PHASES, results_seen);
    $display("Status mix: ok %0d, full %0d, empty %0d, small %0d, fail %0d; peak fill %0d.",
             status_hits[lpmr_pkg::ST_OK], status_hits[lpmr_pkg::ST_FULL],
             status_hits[lpmr_pkg::ST_EMPTY], status_hits[lpmr_pkg::ST_SMALL],
             status_hits[lpmr_pkg::ST_FAIL], peak_fill);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Compare each strobed result against the oldest outstanding prediction
  always @(posedge clk) begin : result_check
    ring_result_t want;
    if (rst_n && out_valid === 1'b1) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        if (mismatches < REPORT_LIMIT)
          $display("[%0d] result with none pending: status %0d len %0d data %02h last %0d",
                   cycles, out_status, out_message_length, out_data_out, out_last);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        status_hits[want.status]++;
        if (out_status !== want.status || out_message_length !== want.msg_len ||
            out_data_out !== want.data || out_last !== want.last) begin
          if (mismatches < REPORT_LIMIT)
            $display({"[%0d] mismatch: want st %0d len %0d data %02h last %0d,",
                      " got st %0d len %0d data %02h last %0d"},
                     cycles, want.status, want.msg_len, want.data, want.last,
                     out_status, out_message_length, out_data_out, out_last);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: end a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycles, pending_results.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

endmodule
